>>> rtl/core/binary_window_lookup_filter_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the binary window lookup filter core
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BINARY_WINDOW_LOOKUP_FILTER_CORE_DEFINES_SVH
`define BINARY_WINDOW_LOOKUP_FILTER_CORE_DEFINES_SVH

// Condition that holds at every clock edge out of reset
`define BLWF_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Consequence that holds in the same cycle as its trigger
`define BLWF_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/blwf_pkg.sv
// ----------------------------------------------------------------------------
// blwf_pkg
// Shared types, constants and helpers of the binary window lookup filter.
// ----------------------------------------------------------------------------
`default_nettype none

package blwf_pkg;

    localparam int TABLE_WORDS   = 8;
    localparam int TABLE_WORD_W  = 64;
    localparam int TABLE_ENTRIES = TABLE_WORDS * TABLE_WORD_W;
    localparam int CFG_AW        = 3;
    localparam int WIN_W         = 9;
    localparam int LIT_W         = 17;
    localparam logic [LIT_W-1:0] LIT_MAX = {LIT_W{1'b1}};

    // result queue geometry, depth is a power of two
    localparam int RES_AW    = 3;
    localparam int RES_DEPTH = 1 << RES_AW;
    localparam int RES_CW    = RES_AW + 1;

    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 24;

    localparam logic FUNC_PIXEL = 1'b0;
    localparam logic FUNC_DRAIN = 1'b1;

    typedef enum logic {
        CMD_PIXEL,
        CMD_DRAIN
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t kind;
        logic      pixel;
        logic      first;
        logic      row_ge1;
        logic      row_ge2;
        logic      emit_a;
        logic      emit_b;
        logic      last;
    } cmd_t;

    typedef struct packed {
        logic [1:0]       cnt;
        logic [WIN_W-1:0] idx0;
        logic [WIN_W-1:0] idx1;
        logic             lrow0;
        logic             lframe0;
    } lookup_t;

    typedef struct packed {
        logic [LIT_W-1:0] lit_count;
        logic             last_in_frame;
        logic             last_in_row;
        logic             pixel_out;
    } result_t;

    // window holds columns left to right, each as top/mid/bottom;
    // the table index is row-major with the top-left pixel as bit 8
    function automatic logic [WIN_W-1:0] win_index(input logic [WIN_W-1:0] win);
        win_index = {win[8], win[5], win[2], win[7], win[4], win[1], win[6], win[3], win[0]};
    endfunction

    function automatic logic [1:0] cmd_results(input cmd_t c);
        cmd_results = {1'b0, c.emit_a} + {1'b0, c.emit_b};
    endfunction

    function automatic logic [LIT_W-1:0] lit_add(input logic [LIT_W-1:0] total,
                                                 input logic px);
        lit_add = (px && (total != LIT_MAX)) ? total + LIT_W'(1) : total;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/blwf_front.sv
// ----------------------------------------------------------------------------
// blwf_front
// Classifies each input transaction, tracks column, row, width and drain
// position, and issues commands for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module blwf_front #(
    parameter int MAX_WIDTH = 256,
    localparam int AW = $clog2(MAX_WIDTH),
    localparam int FW = $clog2(MAX_WIDTH + 1)
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           accept,
    input  logic           func,
    input  logic           pixel,
    input  logic           row_end,
    output logic           push,
    output blwf_pkg::cmd_t cmd,
    output logic [AW-1:0]  addr
);
    import blwf_pkg::*;

    logic [AW-1:0] col_reg, col_next;
    logic [1:0]    row_reg, row_next;      // completed rows, saturating at two
    logic [FW-1:0] width_reg, width_next;
    logic [AW-1:0] drain_reg, drain_next;

    logic          row_ge1, row_ge2, width_known, is_end, drain_ok, drain_last;
    logic [FW-1:0] col_inc, drain_inc;

    always_comb
    begin
        row_ge1     = (row_reg != 2'd0);
        row_ge2     = row_reg[1];
        width_known = (width_reg != '0);
        col_inc     = FW'(col_reg) + FW'(1);
        drain_inc   = FW'(drain_reg) + FW'(1);
        is_end      = width_known ? (col_inc >= width_reg)
                                  : (row_end || (col_reg == AW'(MAX_WIDTH - 1)));
        drain_ok    = row_ge1 && (col_reg == '0) && width_known;
        drain_last  = (drain_inc >= width_reg);
    end

    always_comb
    begin
        col_next   = col_reg;
        row_next   = row_reg;
        width_next = width_reg;
        drain_next = drain_reg;
        push       = 1'b0;
        cmd        = '0;
        cmd.kind   = CMD_PIXEL;
        addr       = col_reg;
        if (accept)
        begin
            if (func == FUNC_DRAIN)
            begin
                // drop a drain tick out of place
                if (drain_ok)
                begin
                    push        = 1'b1;
                    cmd.kind    = CMD_DRAIN;
                    cmd.first   = (drain_reg == '0);
                    cmd.row_ge1 = 1'b1;
                    cmd.row_ge2 = row_ge2;
                    cmd.emit_a  = 1'b1;
                    cmd.last    = drain_last;
                    addr        = drain_inc[AW-1:0];
                    if (drain_last)
                    begin
                        col_next   = '0;
                        row_next   = 2'd0;
                        width_next = '0;
                        drain_next = '0;
                    end
                    else
                    begin
                        drain_next = drain_inc[AW-1:0];
                    end
                end
            end
            else if (drain_reg == '0)
            begin
                push        = 1'b1;
                cmd.kind    = CMD_PIXEL;
                cmd.pixel   = pixel;
                cmd.first   = (col_reg == '0);
                cmd.row_ge1 = row_ge1;
                cmd.row_ge2 = row_ge2;
                cmd.emit_a  = row_ge1 && (col_reg != '0);
                cmd.emit_b  = is_end && row_ge1;
                addr        = col_reg;
                if (is_end)
                begin
                    if (!width_known)
                    begin
                        width_next = col_inc;
                    end
                    col_next = '0;
                    row_next = row_ge2 ? row_reg : row_reg + 2'd1;
                end
                else
                begin
                    col_next = col_inc[AW-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= 2'd0;
            width_reg <= '0;
            drain_reg <= '0;
        end
        else
        begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            width_reg <= width_next;
            drain_reg <= drain_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/blwf_cmd_queue.sv
// ----------------------------------------------------------------------------
// blwf_cmd_queue
// Short first-in first-out queue of commands between front and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module blwf_cmd_queue #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4,
    localparam int PW = $clog2(DEPTH),
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] head,
    output logic             valid
);
    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    always_comb
    begin
        full  = (count_reg == CW'(DEPTH));
        valid = (count_reg != '0);
        head  = entry_reg[rd_ptr_reg];

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        count_next = count_reg + CW'(push) - CW'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/blwf_result_queue.sv
// ----------------------------------------------------------------------------
// blwf_result_queue
// Output queue taking up to two results a cycle and handing out one.
// ----------------------------------------------------------------------------
`default_nettype none

module blwf_result_queue (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [1:0]                    push_cnt,
    input  blwf_pkg::result_t             push_data0,
    input  blwf_pkg::result_t             push_data1,
    input  logic                          pop,
    output blwf_pkg::result_t             head,
    output logic                          valid,
    output logic [blwf_pkg::RES_CW-1:0]   free_cnt
);
    import blwf_pkg::*;

    result_t         entry_reg [RES_DEPTH];
    logic [RES_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [RES_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [RES_CW-1:0] count_reg, count_next;

    always_comb
    begin
        valid       = (count_reg != '0);
        head        = entry_reg[rd_ptr_reg];
        free_cnt    = RES_CW'(RES_DEPTH) - count_reg;
        wr_ptr_next = wr_ptr_reg + RES_AW'(push_cnt);
        rd_ptr_next = rd_ptr_reg + RES_AW'(pop);
        count_next  = count_reg + RES_CW'(push_cnt) - RES_CW'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= push_data0;
        end
        if (push_cnt == 2'd2)
        begin
            entry_reg[wr_ptr_reg + RES_AW'(1)] <= push_data1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/blwf_back.sv
// ----------------------------------------------------------------------------
// blwf_back
// Back end: line store, 3x3 window, table lookup and lit pixel count.
// ----------------------------------------------------------------------------
`default_nettype none

`include "binary_window_lookup_filter_core_defines.svh"

module blwf_back #(
    parameter int MAX_WIDTH = 256,
    localparam int AW = $clog2(MAX_WIDTH)
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [blwf_pkg::CFG_AW-1:0]           cfg_addr,
    input  logic [blwf_pkg::TABLE_WORD_W-1:0]     cfg_data,
    input  logic                                  cmd_valid,
    input  blwf_pkg::cmd_t                        cmd,
    input  logic [AW-1:0]                         cmd_addr,
    output logic                                  cmd_pop,
    input  logic [blwf_pkg::RES_CW-1:0]           free_cnt,
    output logic [1:0]                            push_cnt,
    output blwf_pkg::result_t                     push_data0,
    output blwf_pkg::result_t                     push_data1
);
    import blwf_pkg::*;

    logic [TABLE_WORD_W-1:0] table_reg [TABLE_WORDS];
    logic [TABLE_ENTRIES-1:0] table_flat;

    logic [1:0] line_mem [MAX_WIDTH];

    // fetch stage: command plus registered line store read
    logic          fe_valid_reg;
    cmd_t          fe_cmd_reg;
    logic [AW-1:0] fe_addr_reg;
    logic          fe_fwd_hit_reg;
    logic [1:0]    fe_fwd_data_reg;
    logic [1:0]    rd_data_reg;

    logic [WIN_W-1:0] window_reg, window_next;
    logic [1:0]       shadow_reg, shadow_next;   // copy of line store entry 0
    logic             background_reg, background_next;
    logic [LIT_W-1:0] lit_reg, lit_next;

    lookup_t lk_reg, lk_next;

    logic              admit;
    logic [RES_CW-1:0] reserved_cnt;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [1:0]        wr_data;
    logic [1:0]        old;
    logic [2:0]        bgt, col0_trip, coln_trip;
    logic              top_old, mid_old;
    logic [WIN_W-1:0]  base_win, exe_win, idx_a, idx_b;
    logic              px0, px1;
    logic [LIT_W-1:0]  lit1, lit2;

    always_comb
    begin
        for (int w = 0; w < TABLE_WORDS; w++)
        begin
            table_flat[w*TABLE_WORD_W +: TABLE_WORD_W] = table_reg[w];
        end
    end

    // admit a command only when the result queue has room for every result in flight
    always_comb
    begin
        reserved_cnt = RES_CW'(fe_valid_reg ? cmd_results(fe_cmd_reg) : 2'd0)
                     + RES_CW'(lk_reg.cnt);
        admit        = cmd_valid && (free_cnt >= reserved_cnt + RES_CW'(cmd_results(cmd)));
        cmd_pop      = admit;
    end

    // execute: build the window and, for pixel commands, update the line store
    always_comb
    begin
        old       = fe_fwd_hit_reg ? fe_fwd_data_reg : rd_data_reg;
        bgt       = {3{background_reg}};
        top_old   = fe_cmd_reg.row_ge2 ? old[1] : background_reg;
        mid_old   = fe_cmd_reg.row_ge1 ? old[0] : background_reg;
        col0_trip = {fe_cmd_reg.row_ge2 ? shadow_reg[1] : background_reg,
                     shadow_reg[0], background_reg};
        coln_trip = fe_cmd_reg.last ? bgt : {top_old, mid_old, background_reg};

        wr_en           = 1'b0;
        wr_addr         = fe_addr_reg;
        wr_data         = {old[0], fe_cmd_reg.pixel};
        window_next     = window_reg;
        shadow_next     = shadow_reg;
        background_next = background_reg;
        lk_next         = '0;
        base_win        = window_reg;
        exe_win         = window_reg;
        idx_a           = win_index(window_reg);
        idx_b           = idx_a;

        if (fe_valid_reg)
        begin
            unique case (fe_cmd_reg.kind)
                CMD_PIXEL:
                begin
                    base_win    = fe_cmd_reg.first ? {bgt, bgt, bgt} : window_reg;
                    exe_win     = {base_win[5:0], top_old, mid_old, fe_cmd_reg.pixel};
                    idx_a       = win_index(exe_win);
                    idx_b       = win_index({exe_win[5:0], bgt});
                    wr_en       = 1'b1;
                    window_next = exe_win;
                    if (fe_cmd_reg.first)
                    begin
                        shadow_next = wr_data;
                    end
                    lk_next.cnt     = cmd_results(fe_cmd_reg);
                    lk_next.idx0    = fe_cmd_reg.emit_a ? idx_a : idx_b;
                    lk_next.idx1    = idx_b;
                    lk_next.lrow0   = !fe_cmd_reg.emit_a;
                    lk_next.lframe0 = 1'b0;
                end
                CMD_DRAIN:
                begin
                    base_win    = fe_cmd_reg.first ? {bgt, bgt, col0_trip} : window_reg;
                    exe_win     = {base_win[5:0], coln_trip};
                    idx_a       = win_index(exe_win);
                    idx_b       = idx_a;
                    window_next = exe_win;
                    lk_next.cnt     = 2'd1;
                    lk_next.idx0    = idx_a;
                    lk_next.idx1    = idx_b;
                    lk_next.lrow0   = fe_cmd_reg.last;
                    lk_next.lframe0 = fe_cmd_reg.last;
                    // background of the next frame is the table output for the all-background window
                    if (fe_cmd_reg.last)
                    begin
                        background_next = background_reg ? table_flat[TABLE_ENTRIES-1]
                                                         : table_flat[0];
                    end
                end
                default:
                begin
                    lk_next = '0;
                end
            endcase
        end
    end

    // lookup stage: table read, lit count and result hand-off
    always_comb
    begin
        px0  = table_flat[lk_reg.idx0];
        px1  = table_flat[lk_reg.idx1];
        lit1 = lit_add(lit_reg, px0);
        lit2 = lit_add(lit1, px1);

        push_cnt                 = lk_reg.cnt;
        push_data0.pixel_out     = px0;
        push_data0.last_in_row   = lk_reg.lrow0;
        push_data0.last_in_frame = lk_reg.lframe0;
        push_data0.lit_count     = lk_reg.lframe0 ? lit1 : '0;
        push_data1.pixel_out     = px1;
        push_data1.last_in_row   = 1'b1;
        push_data1.last_in_frame = 1'b0;
        push_data1.lit_count     = '0;

        priority if (lk_reg.cnt == 2'd0)
        begin
            lit_next = lit_reg;
        end
        else if (lk_reg.lframe0)
        begin
            lit_next = '0;
        end
        else if (lk_reg.cnt == 2'd2)
        begin
            lit_next = lit2;
        end
        else
        begin
            lit_next = lit1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            line_mem[wr_addr] <= wr_data;
        end
        if (admit)
        begin
            rd_data_reg <= line_mem[cmd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (admit)
        begin
            fe_cmd_reg      <= cmd;
            fe_addr_reg     <= cmd_addr;
            // forward the write that lands in the same cycle as the read
            fe_fwd_hit_reg  <= wr_en && (wr_addr == cmd_addr);
            fe_fwd_data_reg <= wr_data;
        end
        window_reg <= window_next;
        shadow_reg <= shadow_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int w = 0; w < TABLE_WORDS; w++)
            begin
                table_reg[w] <= '0;
            end
            fe_valid_reg   <= 1'b0;
            lk_reg         <= '0;
            background_reg <= 1'b0;
            lit_reg        <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                table_reg[cfg_addr] <= cfg_data;
            end
            fe_valid_reg   <= admit;
            lk_reg         <= lk_next;
            background_reg <= background_next;
            lit_reg        <= lit_next;
        end
    end

    `BLWF_ASSERT_ALWAYS(a_credit_bound, reserved_cnt <= free_cnt, "results in flight exceed queue room")
    `BLWF_ASSERT_IMP(a_push_fits, push_cnt != 2'd0, RES_CW'(push_cnt) <= free_cnt, "result push overflows queue")
    `BLWF_ASSERT_IMP(a_fwd_source, fe_valid_reg && fe_fwd_hit_reg, $past(wr_en) && ($past(wr_addr) == fe_addr_reg), "forwarded line data without a matching write")

endmodule

`default_nettype wire

>>> rtl/core/binary_window_lookup_filter_core.sv
// ----------------------------------------------------------------------------
// binary_window_lookup_filter_core
// Binary 3x3 neighbourhood lookup filter over a streamed raster.
//
//   Channel   Direction  Handshake          Payload
//   s_*       in         tvalid/tready      tdata[0] pixel_in, tlast row_end,
//                                           tuser func
//   m_*       out        tvalid/tready      tdata pixel_out, lit_count,
//                                           tlast last_in_row, tuser last_in_frame
//   cfg_*     in         cfg_we, no stall   table word index and data
//
// One input transaction per cycle while the command queue has room; the line
// store takes one read and one write per cycle, which sets that rate. After the
// first row a row-end pixel yields up to two results, drained one a cycle.
// Reset clears counters, queues, table and background; the line store is not
// cleared. Either side may stall: commands queue behind the front end and
// results wait in the output queue.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_window_lookup_filter_core #(
    parameter int MAX_WIDTH = 256
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [blwf_pkg::S_TDATA_W-1:0]        s_tdata,   // [0] pixel_in
    input  logic                                  s_tlast,   // row_end
    input  logic                                  s_tuser,   // func
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [blwf_pkg::M_TDATA_W-1:0]        m_tdata,   // [0] pixel_out, [17:1] lit_count
    output logic                                  m_tlast,   // last_in_row
    output logic                                  m_tuser,   // last_in_frame
    input  logic                                  cfg_we,
    input  logic [blwf_pkg::CFG_AW-1:0]           cfg_addr,
    input  logic [blwf_pkg::TABLE_WORD_W-1:0]     cfg_data
);
    import blwf_pkg::*;

    localparam int AW        = $clog2(MAX_WIDTH);
    localparam int CMD_W     = $bits(cmd_t);
    localparam int CQ_W      = CMD_W + AW;
    localparam int CQ_DEPTH  = 4;

    logic              accept;
    logic              fr_push;
    cmd_t              fr_cmd;
    logic [AW-1:0]     fr_addr;
    logic              cq_full, cq_valid, cq_pop;
    logic [CQ_W-1:0]   cq_head;
    cmd_t              bk_cmd;
    logic [AW-1:0]     bk_addr;
    logic [RES_CW-1:0] free_cnt;
    logic [1:0]        push_cnt;
    result_t           push_data0, push_data1, res_head;
    logic              res_pop;

    assign s_tready = !cq_full;
    assign accept   = s_tvalid && s_tready;
    assign bk_cmd   = cmd_t'(cq_head[CMD_W-1:0]);
    assign bk_addr  = cq_head[CQ_W-1 -: AW];
    assign res_pop  = m_tvalid && m_tready;

    assign m_tdata = {(M_TDATA_W - LIT_W - 1)'(0), res_head.lit_count, res_head.pixel_out};
    assign m_tlast = res_head.last_in_row;
    assign m_tuser = res_head.last_in_frame;

    blwf_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .func    (s_tuser),
        .pixel   (s_tdata[0]),
        .row_end (s_tlast),
        .push    (fr_push),
        .cmd     (fr_cmd),
        .addr    (fr_addr)
    );

    blwf_cmd_queue #(
        .WIDTH (CQ_W),
        .DEPTH (CQ_DEPTH)
    ) u_cmd_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fr_push),
        .push_data ({fr_addr, fr_cmd}),
        .full      (cq_full),
        .pop       (cq_pop),
        .head      (cq_head),
        .valid     (cq_valid)
    );

    blwf_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_data   (cfg_data),
        .cmd_valid  (cq_valid),
        .cmd        (bk_cmd),
        .cmd_addr   (bk_addr),
        .cmd_pop    (cq_pop),
        .free_cnt   (free_cnt),
        .push_cnt   (push_cnt),
        .push_data0 (push_data0),
        .push_data1 (push_data1)
    );

    blwf_result_queue u_result_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_cnt   (push_cnt),
        .push_data0 (push_data0),
        .push_data1 (push_data1),
        .pop        (res_pop),
        .head       (res_head),
        .valid      (m_tvalid),
        .free_cnt   (free_cnt)
    );

endmodule

`default_nettype wire
